### sv/cgbd_pkg.sv
// Shared types, codes and decode tables for the bitplane decompressor.
package cgbd_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_FETCH = 2'd2;
    localparam logic [1:0] PLANE_FIXED = 2'd0;
    localparam logic [1:0] PLANE_STEP  = 2'd1;
    localparam logic [1:0] PLANE_SWAP  = 2'd2;
    localparam logic [1:0] PLANE_ALL  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD0, ST_LOAD1, ST_START0, ST_START1, ST_START2,
        ST_FETCH, ST_BIT_CTX, ST_BIT_CHK, ST_CW_A, ST_CW_M1, ST_CW_B,
        ST_CW_M2, ST_APPLY, ST_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_IDLE, CMD_LOAD0, CMD_LOAD1, CMD_START0, CMD_START1,
        CMD_START2, CMD_FETCH, CMD_BIT_CTX, CMD_BIT_CHK, CMD_CW_A, CMD_CW_M1,
        CMD_CW_B, CMD_CW_M2, CMD_APPLY, CMD_EMIT
    } dp_cmd_t;

    typedef struct packed {
        logic need_decode;
        logic cw_needed;
        logic win_empty;
        logic short_cw;
        logic refill;
        logic last_bit;
    } dp_status_t;

    localparam logic [2:0] EVO_SIZE [33] = '{
        3'd0,3'd0,3'd0,3'd0,3'd0,3'd1,3'd1,3'd1,3'd1,3'd2,3'd2,3'd2,3'd2,
        3'd3,3'd3,3'd3,3'd3,3'd4,3'd4,3'd5,3'd5,3'd6,3'd6,3'd7,3'd7,
        3'd0,3'd1,3'd2,3'd3,3'd4,3'd5,3'd6,3'd7};
    localparam logic [5:0] EVO_MPS [33] = '{
        6'd25,6'd2,6'd3,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,6'd10,6'd11,6'd12,6'd13,
        6'd14,6'd15,6'd16,6'd17,6'd18,6'd19,6'd20,6'd21,6'd22,6'd23,6'd24,6'd24,
        6'd26,6'd27,6'd28,6'd29,6'd30,6'd31,6'd32,6'd24};
    localparam logic [5:0] EVO_LPS [33] = '{
        6'd25,6'd1,6'd1,6'd2,6'd3,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,6'd10,6'd11,
        6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,6'd18,6'd19,6'd20,6'd21,6'd22,6'd23,
        6'd1,6'd2,6'd4,6'd8,6'd12,6'd16,6'd18,6'd22};

    localparam logic [7:0] RUN_LEN [128] = '{
        8'd128,8'd64,8'd96,8'd32,8'd112,8'd48,8'd80,8'd16,
        8'd120,8'd56,8'd88,8'd24,8'd104,8'd40,8'd72,8'd8,
        8'd124,8'd60,8'd92,8'd28,8'd108,8'd44,8'd76,8'd12,
        8'd116,8'd52,8'd84,8'd20,8'd100,8'd36,8'd68,8'd4,
        8'd126,8'd62,8'd94,8'd30,8'd110,8'd46,8'd78,8'd14,
        8'd118,8'd54,8'd86,8'd22,8'd102,8'd38,8'd70,8'd6,
        8'd122,8'd58,8'd90,8'd26,8'd106,8'd42,8'd74,8'd10,
        8'd114,8'd50,8'd82,8'd18,8'd98,8'd34,8'd66,8'd2,
        8'd127,8'd63,8'd95,8'd31,8'd111,8'd47,8'd79,8'd15,
        8'd119,8'd55,8'd87,8'd23,8'd103,8'd39,8'd71,8'd7,
        8'd123,8'd59,8'd91,8'd27,8'd107,8'd43,8'd75,8'd11,
        8'd115,8'd51,8'd83,8'd19,8'd99,8'd35,8'd67,8'd3,
        8'd125,8'd61,8'd93,8'd29,8'd109,8'd45,8'd77,8'd13,
        8'd117,8'd53,8'd85,8'd21,8'd101,8'd37,8'd69,8'd5,
        8'd121,8'd57,8'd89,8'd25,8'd105,8'd41,8'd73,8'd9,
        8'd113,8'd49,8'd81,8'd17,8'd97,8'd33,8'd65,8'd1};

endpackage

### sv/cgbd_ctrl.sv
// Controller state machine that sequences load, start and fetch items.
module cgbd_ctrl
    import cgbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        can_emit;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign can_emit = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        MODE_LOAD:  state_next = ST_LOAD0;
                        MODE_START: state_next = ST_START0;
                        MODE_FETCH: state_next = ST_FETCH;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD0:   state_next = ST_LOAD1;
            ST_LOAD1:   state_next = ST_IDLE;
            ST_START0:  state_next = ST_START1;
            ST_START1:  state_next = ST_START2;
            ST_START2:  state_next = ST_IDLE;
            ST_FETCH:   state_next = status.need_decode ? ST_BIT_CTX : ST_DONE;
            ST_BIT_CTX: state_next = ST_BIT_CHK;
            ST_BIT_CHK: state_next = status.cw_needed ? ST_CW_A : ST_APPLY;
            ST_CW_A:    state_next = status.win_empty ? ST_CW_M1 : ST_CW_B;
            ST_CW_M1:   state_next = ST_CW_B;
            ST_CW_B: begin
                if (!status.short_cw && status.refill) begin
                    state_next = ST_CW_M2;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_CW_M2:   state_next = ST_APPLY;
            ST_APPLY:   state_next = status.last_bit ? ST_DONE : ST_BIT_CTX;
            ST_DONE:    state_next = can_emit ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = CMD_NONE;
        case (state_reg)
            ST_IDLE:    cmd = CMD_IDLE;
            ST_LOAD0:   cmd = CMD_LOAD0;
            ST_LOAD1:   cmd = CMD_LOAD1;
            ST_START0:  cmd = CMD_START0;
            ST_START1:  cmd = CMD_START1;
            ST_START2:  cmd = CMD_START2;
            ST_FETCH:   cmd = CMD_FETCH;
            ST_BIT_CTX: cmd = CMD_BIT_CTX;
            ST_BIT_CHK: cmd = CMD_BIT_CHK;
            ST_CW_A:    cmd = CMD_CW_A;
            ST_CW_M1:   cmd = CMD_CW_M1;
            ST_CW_B:    cmd = CMD_CW_B;
            ST_CW_M2:   cmd = CMD_CW_M2;
            ST_APPLY:   cmd = CMD_APPLY;
            ST_DONE:    cmd = can_emit ? CMD_EMIT : CMD_NONE;
            default:    cmd = CMD_NONE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_DONE && can_emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### sv/cgbd_datapath.sv
// Datapath with the compressed buffer, bit window, run decoders and contexts.
module cgbd_datapath
    import cgbd_pkg::*;
#(
    parameter int BUF_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    input  logic [11:0] s_load_address,
    input  logic [7:0]  s_load_data,
    output dp_status_t  status,
    output logic [7:0]  m_out_byte,
    output logic        m_read_overrun
);

    localparam int AW    = $clog2(BUF_DEPTH);
    localparam int SHIFT = 20;
    localparam int RECIP = (1 << SHIFT) / BUF_DEPTH;

    logic [7:0]  mem [BUF_DEPTH];
    logic [7:0]  rdata_reg;
    logic [11:0] addr_in_reg;
    logic [7:0]  data_in_reg;
    logic [11:0] q_reg;
    logic [7:0]  b0_reg;

    logic [AW-1:0] ptr_reg;
    logic          ovr_reg;
    logic [15:0]   win_reg;
    logic [3:0]    wvc_reg;
    logic [7:0]    run_reg  [8];
    logic [5:0]    cps_reg  [32];
    logic          mps_reg  [32];
    logic [8:0]    hist_reg [8];
    logic [1:0]    pm_reg;
    logic [8:0]    hmask_reg;
    logic [1:0]    lmask_reg;
    logic [2:0]    cur_reg;
    logic [3:0]    phase_reg;
    logic [7:0]    pend_reg;

    logic [3:0]        idx_reg;
    logic [2:0]        plane_reg;
    logic [4:0]        ctx_reg;
    logic [5:0]        st_reg;
    logic [2:0]        k_reg;
    logic [7:0]        rc_reg;
    logic [15:0]       w_reg;
    logic signed [4:0] cnt_reg;
    logic [7:0]        byte_reg;
    logic [7:0]        nxt_reg;
    logic [7:0]        out_byte_reg;
    logic              out_ovr_reg;

    logic [2:0]        base_plane;
    logic [2:0]        plane_sel;
    logic [8:0]        hist_sel;
    logic [4:0]        ctx_c;
    logic [5:0]        st_raw;
    logic [5:0]        st_c;
    logic [3:0]        phase_inc;
    logic [31:0]       q_prod;
    logic [31:0]       rem_a;
    logic [31:0]       rem_b;
    logic [AW-1:0]     wr_addr;
    logic [AW:0]       ptr_inc;
    logic [AW-1:0]     ptr_next;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [15:0]       w1;
    logic signed [4:0] c1;
    logic [6:0]        cw_idx;
    logic [15:0]       w2;
    logic signed [4:0] c2;
    logic [4:0]        neg_cnt;
    logic [7:0]        r_dec;
    logic              g_last;
    logic              g_lps;
    logic              mps_old;
    logic              bit_val;
    logic [7:0]        bit_mask;
    logic [7:0]        byte_new;
    logic [7:0]        nxt_new;

    assign base_plane = (pm_reg == PLANE_FIXED) ? 3'd0 : cur_reg;
    assign plane_sel  = (pm_reg == PLANE_ALL) ? idx_reg[2:0]
                                              : base_plane + {2'b0, idx_reg[0]};
    assign hist_sel   = hist_reg[plane_sel];
    assign ctx_c      = {plane_sel[0], 4'b0} | 5'((hist_sel & hmask_reg) >> 5)
                      | {3'b0, hist_sel[1:0] & lmask_reg};
    assign st_raw     = cps_reg[ctx_c];
    assign st_c       = (st_raw > 6'd32) ? 6'd0 : st_raw;
    assign phase_inc  = phase_reg + 4'd1;

    assign q_prod  = 32'(addr_in_reg) * 32'(RECIP);
    assign rem_a   = 32'(addr_in_reg) - 32'(q_reg) * 32'(BUF_DEPTH);
    assign rem_b   = (rem_a >= 32'(BUF_DEPTH)) ? rem_a - 32'(BUF_DEPTH) : rem_a;
    assign wr_addr = rem_b[AW-1:0];

    assign ptr_inc  = {1'b0, ptr_reg} + {{AW{1'b0}}, 1'b1};
    assign ptr_next = (32'(ptr_inc) >= 32'(BUF_DEPTH)) ? '0 : ptr_inc[AW-1:0];

    assign w1      = {w_reg[14:0], 1'b0} ^ 16'h8000;
    assign c1      = cnt_reg - 5'sd1;
    assign cw_idx  = w1[14:8] | (7'h7f >> k_reg);
    assign w2      = w1 << k_reg;
    assign c2      = c1 - $signed({2'b0, k_reg});
    assign neg_cnt = 5'(-cnt_reg);

    assign r_dec   = rc_reg - 8'd1;
    assign g_last  = (r_dec == 8'h80);
    assign g_lps   = (r_dec == 8'h00);
    assign mps_old = mps_reg[ctx_reg];
    assign bit_val = g_lps ? ~mps_old : mps_old;

    always_comb begin
        bit_mask = 8'(8'h01 << idx_reg[2:0]);
        if (pm_reg != PLANE_ALL) begin
            bit_mask = 8'(8'h80 >> idx_reg[3:1]);
        end
        byte_new = byte_reg;
        nxt_new  = nxt_reg;
        if (bit_val) begin
            if (pm_reg == PLANE_ALL || !idx_reg[0]) begin
                byte_new = byte_reg | bit_mask;
            end else begin
                nxt_new = nxt_reg | bit_mask;
            end
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg;
        case (cmd)
            CMD_START0: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            CMD_START1: begin
                rd_en   = 1'b1;
                rd_addr = AW'(1);
            end
            CMD_CW_A:   rd_en = (wvc_reg == 4'd0);
            CMD_CW_B:   rd_en = !w1[15] && (c2 < 0);
            default:    rd_en = 1'b0;
        endcase
    end

    assign status.need_decode = (pm_reg == PLANE_ALL) || phase_inc[0];
    assign status.cw_needed   = (run_reg[k_reg] == 8'd0);
    assign status.win_empty   = (wvc_reg == 4'd0);
    assign status.short_cw    = w1[15];
    assign status.refill      = (c2 < 0);
    assign status.last_bit    = (pm_reg == PLANE_ALL) ? (idx_reg == 4'd7)
                                                      : (idx_reg == 4'd15);

    assign m_out_byte     = out_byte_reg;
    assign m_read_overrun = out_ovr_reg;

    always_ff @(posedge aclk) begin
        if (cmd == CMD_LOAD1) begin
            mem[wr_addr] <= data_in_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_IDLE: begin
                addr_in_reg <= s_load_address;
                data_in_reg <= s_load_data;
            end
            CMD_LOAD0:  q_reg <= q_prod[SHIFT +: 12];
            CMD_START1: b0_reg <= rdata_reg;
            CMD_FETCH: begin
                idx_reg  <= '0;
                byte_reg <= status.need_decode ? 8'd0 : pend_reg;
                nxt_reg  <= '0;
            end
            CMD_BIT_CTX: begin
                plane_reg <= plane_sel;
                ctx_reg   <= ctx_c;
                st_reg    <= st_c;
                k_reg     <= EVO_SIZE[st_c];
            end
            CMD_BIT_CHK: rc_reg <= run_reg[k_reg];
            CMD_CW_A: begin
                w_reg   <= win_reg;
                cnt_reg <= $signed({1'b0, wvc_reg});
            end
            CMD_CW_M1: begin
                w_reg   <= w_reg | {8'b0, rdata_reg};
                cnt_reg <= 5'sd8;
            end
            CMD_CW_B: begin
                if (w1[15]) begin
                    rc_reg <= 8'(8'h80 + (8'h01 << k_reg));
                end else begin
                    rc_reg  <= RUN_LEN[cw_idx];
                    w_reg   <= w2;
                    cnt_reg <= c2;
                end
            end
            CMD_APPLY: begin
                idx_reg  <= idx_reg + 4'd1;
                byte_reg <= byte_new;
                nxt_reg  <= nxt_new;
            end
            CMD_EMIT: begin
                out_byte_reg <= byte_reg;
                out_ovr_reg  <= ovr_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            ovr_reg   <= 1'b0;
            win_reg   <= '0;
            wvc_reg   <= '0;
            pm_reg    <= '0;
            hmask_reg <= '0;
            lmask_reg <= '0;
            cur_reg   <= '0;
            phase_reg <= '0;
            pend_reg  <= '0;
            for (int i = 0; i < 8; i++) begin
                run_reg[i]  <= '0;
                hist_reg[i] <= '0;
            end
            for (int i = 0; i < 32; i++) begin
                cps_reg[i] <= '0;
                mps_reg[i] <= 1'b0;
            end
        end else begin
            if (rd_en && (cmd == CMD_CW_A || cmd == CMD_CW_B)) begin
                ptr_reg <= ptr_next;
                if (ptr_reg == '0) begin
                    ovr_reg <= 1'b1;
                end
            end
            case (cmd)
                CMD_START2: begin
                    pm_reg <= b0_reg[7:6];
                    case (b0_reg[5:4])
                        2'd0: begin
                            hmask_reg <= 9'h1c0;
                            lmask_reg <= 2'h1;
                        end
                        2'd1: begin
                            hmask_reg <= 9'h180;
                            lmask_reg <= 2'h1;
                        end
                        2'd2: begin
                            hmask_reg <= 9'h0c0;
                            lmask_reg <= 2'h1;
                        end
                        default: begin
                            hmask_reg <= 9'h180;
                            lmask_reg <= 2'h3;
                        end
                    endcase
                    win_reg   <= {b0_reg[4:0], rdata_reg, 3'b0};
                    wvc_reg   <= 4'd5;
                    ptr_reg   <= AW'(2);
                    ovr_reg   <= 1'b0;
                    cur_reg   <= '0;
                    phase_reg <= '0;
                    for (int i = 0; i < 8; i++) begin
                        run_reg[i]  <= '0;
                        hist_reg[i] <= '0;
                    end
                    for (int i = 0; i < 32; i++) begin
                        cps_reg[i] <= '0;
                        mps_reg[i] <= 1'b0;
                    end
                end
                CMD_FETCH: begin
                    if (pm_reg != PLANE_ALL) begin
                        phase_reg <= phase_inc;
                        if (phase_inc == 4'd0) begin
                            if (pm_reg == PLANE_STEP) begin
                                cur_reg <= cur_reg + 3'd2;
                            end else if (pm_reg == PLANE_SWAP) begin
                                cur_reg <= cur_reg ^ 3'd2;
                            end
                        end
                    end
                end
                CMD_CW_M1: begin
                end
                CMD_CW_B: begin
                    if (w1[15]) begin
                        win_reg <= w1;
                        wvc_reg <= c1[3:0];
                    end else if (c2 >= 0) begin
                        win_reg <= w2;
                        wvc_reg <= c2[3:0];
                    end
                end
                CMD_CW_M2: begin
                    win_reg <= w_reg | 16'({8'b0, rdata_reg} << neg_cnt[2:0]);
                    wvc_reg <= 4'(cnt_reg + 5'sd8);
                end
                CMD_APPLY: begin
                    run_reg[k_reg]      <= g_last ? 8'd0 : r_dec;
                    hist_reg[plane_reg] <= {hist_reg[plane_reg][7:0], bit_val};
                    if (g_lps) begin
                        cps_reg[ctx_reg] <= EVO_LPS[st_reg];
                        if (st_reg < 6'd2) begin
                            mps_reg[ctx_reg] <= ~mps_old;
                        end
                    end else if (g_last) begin
                        cps_reg[ctx_reg] <= EVO_MPS[st_reg];
                    end
                    if (status.last_bit) begin
                        if (pm_reg == PLANE_ALL) begin
                            cur_reg <= '0;
                        end else begin
                            pend_reg <= nxt_new;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### sv/context_golomb_bitplane_decompressor_unit.sv
// Top level of the context-modelled Golomb bitplane decompressor.
// Load item: LOAD0, LOAD1. Start item: START0 to START2. Buffered fetch: FETCH, DONE.
// A decoded fetch item takes 8 or 16 bit decodes, each BIT_CTX, BIT_CHK, codeword states
// as needed and APPLY, set by the serial run decoder step and single buffer read port.
// The result register frees the input side while a result waits to be taken.
// Synchronous active-low reset clears all decoder state; the buffer keeps its contents.
module context_golomb_bitplane_decompressor_unit
    import cgbd_pkg::*;
#(
    parameter int BUF_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [11:0] s_load_address,
    input  logic [7:0]  s_load_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_read_overrun
);

    dp_cmd_t    cmd;
    dp_status_t status;

    cgbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cgbd_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_load_address (s_load_address),
        .s_load_data    (s_load_data),
        .status         (status),
        .m_out_byte     (m_out_byte),
        .m_read_overrun (m_read_overrun)
    );

endmodule
